@@ src/fsaq_pkg.sv @@
// Package with types and codes shared by the frame set assembly queue.
package fsaq_pkg;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_LATE      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_NOT_READY = 3'd5;
  localparam logic [2:0] ST_DELIVERED = 3'd6;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam logic CFG_CAMS  = 1'b0;
  localparam logic CFG_DEPTH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_POP_READ,
    S_POP_EMIT,
    S_STATUS,
    S_OUT_WAIT
  } fsaq_state_t;

endpackage

@@ src/frame_set_assembly_queue.sv @@
// Top level of the frame set assembly queue: slot ring, part memories and sequencer.
//
//  Channel | Direction | Handshake               | Payload
//  in_     | slave     | in_tvalid / in_tready   | in_tdata (put fields), in_tuser (func)
//  out_    | master    | out_tvalid / out_tready | out_tdata (result), out_tuser (kind),
//          |           |                         | out_tlast (final result of a transaction)
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A put scans the live slots of the frame memory one slot per cycle (one read port), and
// a drop adds the release of each part of the dropped slot. A take skips the scan and
// emits each delivered part. The frame search sets the rate. Reset is synchronous
// and active low; slot masks live in flip-flops and are cleared at once, so no clearing
// pass is needed. A stalled out_tready holds the current result in the output register
// and freezes the sequencer in every state after the search; acceptance of a new
// transaction and the frame search itself do not wait for it.
module frame_set_assembly_queue
  import fsaq_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int CAMS  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, from bit 0: frame_index[30:0], cam_index[34:31], handle[66:35],
  // size_bytes[91:67], zero fill to 96 bits.
  input  logic [95:0]  in_tdata,
  // in_tuser: func.
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, from bit 0: status[2:0], out_camera[5:3], out_handle[37:6],
  // out_size[61:38], out_frame[92:62], frames_in[124:93], frames_out[156:125],
  // frames_thrown[188:157], zero fill to 192 bits.
  output logic [191:0] out_tdata,
  // out_tuser: kind.
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [3:0]   cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (CAMS > 1) ? $clog2(CAMS) : 1;
  localparam int NW = $clog2(SLOTS + 1);
  localparam int AW = SW + CW;

  // Configuration registers.
  logic [3:0] cams_cfg_r, depth_cfg_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cams_cfg_r  <= 4'd8;
      depth_cfg_r <= 4'd15;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAMS:  cams_cfg_r  <= cfg_data;
        CFG_DEPTH: depth_cfg_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Cameras needed for a complete set, capped at CAMS.
  logic [5:0] need;
  assign need = ({2'b0, cams_cfg_r} > 6'(CAMS)) ? 6'(CAMS) : {2'b0, cams_cfg_r};

  // Memories: frame per slot, handle and size per part.
  logic [30:0] frame_mem [SLOTS];
  logic [31:0] handle_mem [1 << AW];
  logic [23:0] size_mem [1 << AW];
  logic [CAMS-1:0] mask_r [SLOTS];

  fsaq_state_t state_r, state_nxt;

  // Latched input transaction.
  logic        func_r;
  logic [30:0] fr_r;
  logic [3:0]  cam_r;
  logic [31:0] hdl_r;
  logic        neg_r;
  logic [23:0] size_r;

  logic [SW-1:0] head_r;
  logic [NW-1:0] count_r;
  logic [31:0]   opened_r, delivered_r, dropped_r;

  // Scan state.
  logic [NW-1:0] scan_r;
  logic          scan_v_r;
  logic [SW-1:0] scan_slot_r;
  logic          found_r;
  logic [SW-1:0] found_slot_r;
  logic [30:0]   head_frame_r;

  // Pop state: release (put) or delivery (take).
  logic          pop_deliver_r;
  logic          pop_active_r;
  logic [CW:0]   pop_cam_r;
  logic          pop_then_open_r;

  // Status and output register.
  logic [2:0]  st_r;
  logic [30:0] st_frame_r;
  logic        out_v_r;
  logic [1:0]  o_kind_r;
  logic [2:0]  o_status_r, o_cam_r;
  logic [31:0] o_hdl_r;
  logic [23:0] o_size_r;
  logic [30:0] o_frame_r;
  logic        o_last_r;

  // Frame memory read port.
  logic [SW-1:0] frd_addr;
  logic [30:0]   frd_q_r;
  always_ff @(posedge clk) frd_q_r <= frame_mem[frd_addr];

  // Part memory read port.
  logic [AW-1:0] prd_addr;
  logic [31:0]   hrd_q_r;
  logic [23:0]   srd_q_r;
  always_ff @(posedge clk) begin
    hrd_q_r <= handle_mem[prd_addr];
    srd_q_r <= size_mem[prd_addr];
  end

  logic out_free;
  assign out_free = !out_v_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Scan address: slot (head + scan) mod SLOTS, or the head for a take.
  logic [NW:0] scan_sum;
  assign scan_sum = (NW+1)'(head_r) + (NW+1)'(scan_r);
  logic [SW-1:0] scan_addr;
  assign scan_addr = (scan_sum >= (NW+1)'(SLOTS)) ? SW'(scan_sum - (NW+1)'(SLOTS))
                                                  : SW'(scan_sum);

  // Next present camera of the slot being popped at or after pop_cam_r.
  logic [CAMS-1:0] head_mask;
  assign head_mask = mask_r[head_r];
  logic          nxt_found;
  logic [CW-1:0] nxt_cam;
  always_comb begin
    nxt_found = 1'b0;
    nxt_cam   = '0;
    for (int c = CAMS - 1; c >= 0; c--) begin
      if (head_mask[c] && (CW+1)'(c) >= pop_cam_r) begin
        nxt_found = 1'b1;
        nxt_cam   = CW'(c);
      end
    end
  end
  logic pop_go;
  assign pop_go = pop_active_r && nxt_found;

  logic [5:0] pop_cnt;
  always_comb begin
    pop_cnt = '0;
    for (int c = 0; c < CAMS; c++) pop_cnt = pop_cnt + 6'(head_mask[c]);
  end

  // Tail slot after an optional drop.
  logic [NW:0] tail_sum;
  assign tail_sum = (NW+1)'(head_r) + (NW+1)'(count_r);
  logic [SW-1:0] tail_slot;
  assign tail_slot = (tail_sum >= (NW+1)'(SLOTS)) ? SW'(tail_sum - (NW+1)'(SLOTS))
                                                  : SW'(tail_sum);
  logic [SW-1:0] head_inc;
  assign head_inc = (head_r == SW'(SLOTS - 1)) ? '0 : head_r + SW'(1);

  logic full_drop;
  assign full_drop = ({1'b0, count_r} > (NW+1)'(depth_cfg_r)) ||
                     (count_r >= NW'(SLOTS));
  logic invalid_part;
  assign invalid_part = ({2'b0, cam_r} >= need) || ({1'b0, cam_r} >= 5'(CAMS)) ||
                        (hdl_r == '0) || neg_r;

  // Decisions taken once the scan is over. A late part is checked before validity.
  logic is_late, take_ok, open_new, drop_now;
  assign is_late  = (func_r == FUNC_PUT) && (count_r != '0) && !found_r &&
                    (head_frame_r > fr_r);
  assign take_ok  = (func_r == FUNC_TAKE) && (count_r != '0) && (pop_cnt >= need);
  assign open_new = (func_r == FUNC_PUT) && !is_late && !invalid_part && !found_r;
  assign drop_now = open_new && full_drop;

  // The output register is loaded only when it is free, so no result is overwritten.
  logic out_load;
  assign out_load = out_free && ((state_r == S_DECIDE && is_late) ||
                                 state_r == S_POP_EMIT || state_r == S_OUT_WAIT);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = (in_tuser == FUNC_TAKE) ? S_DECIDE : S_SEARCH;
      S_SEARCH:   if (scan_r == NW'(SLOTS) && !scan_v_r) state_nxt = S_DECIDE;
      S_DECIDE:   if (out_free) state_nxt = S_POP_READ;
      S_POP_READ: if (out_free) state_nxt = pop_go ? S_POP_EMIT : S_STATUS;
      S_POP_EMIT: if (out_free) state_nxt = S_POP_READ;
      S_STATUS:   if (out_free) state_nxt = S_OUT_WAIT;
      S_OUT_WAIT: if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory addresses.
  always_comb begin
    frd_addr = scan_addr;
    prd_addr = {head_r, nxt_cam};
    if (state_r == S_DECIDE || state_r == S_IDLE) frd_addr = head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; count_r <= '0;
      opened_r <= '0; delivered_r <= '0; dropped_r <= '0;
      out_v_r <= 1'b0;
      scan_v_r <= 1'b0;
      for (int s = 0; s < SLOTS; s++) mask_r[s] <= '0;
    end else begin
      if (out_load)        out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          func_r   <= in_tuser;
          fr_r     <= in_tdata[30:0];
          cam_r    <= in_tdata[34:31];
          hdl_r    <= in_tdata[66:35];
          neg_r    <= in_tdata[91];
          size_r   <= in_tdata[91] ? 24'd0 : in_tdata[90:67];
          scan_r   <= '0;
          scan_v_r <= 1'b0;
          found_r  <= 1'b0;
        end
        S_SEARCH: begin
          // Compare the frame read last cycle, then issue the next read.
          if (scan_v_r) begin
            if (scan_r == NW'(1)) head_frame_r <= frd_q_r;
            if (frd_q_r == fr_r) begin
              found_r      <= 1'b1;
              found_slot_r <= scan_slot_r;
            end
          end
          scan_slot_r <= scan_addr;
          if (scan_r < count_r) begin
            scan_v_r <= 1'b1;
            scan_r   <= scan_r + NW'(1);
          end else begin
            scan_v_r <= 1'b0;
            scan_r   <= NW'(SLOTS);
          end
        end
        S_DECIDE: if (out_free) begin
          // Counters move here so that every result of the step carries the final counts.
          pop_cam_r       <= '0;
          pop_deliver_r   <= take_ok;
          pop_active_r    <= take_ok || drop_now;
          pop_then_open_r <= open_new;
          if (take_ok)  delivered_r <= delivered_r + 32'd1;
          if (open_new) opened_r    <= opened_r + 32'd1;
          if (drop_now) dropped_r   <= dropped_r + 32'd1;
          if (func_r == FUNC_TAKE) begin
            st_r       <= take_ok ? ST_DELIVERED : ST_NOT_READY;
            st_frame_r <= (count_r == '0) ? '0 : frd_q_r;
          end else if (is_late) begin
            st_r <= ST_LATE; st_frame_r <= fr_r;
            o_kind_r <= KIND_RELEASE; o_status_r <= ST_LATE;
            o_cam_r <= cam_r[2:0]; o_hdl_r <= hdl_r; o_size_r <= size_r;
            o_frame_r <= fr_r; o_last_r <= 1'b0;
          end else if (invalid_part) begin
            st_r <= ST_INVALID; st_frame_r <= fr_r;
          end else if (!found_r) begin
            st_r <= ST_NEW; st_frame_r <= fr_r;
          end else if (mask_r[found_slot_r][cam_r[CW-1:0]]) begin
            st_r <= ST_DUP; st_frame_r <= fr_r;
          end else begin
            st_r <= ST_ADDED; st_frame_r <= fr_r;
            mask_r[found_slot_r][cam_r[CW-1:0]] <= 1'b1;
            handle_mem[{found_slot_r, cam_r[CW-1:0]}] <= hdl_r;
            size_mem[{found_slot_r, cam_r[CW-1:0]}]   <= size_r;
          end
        end
        S_POP_READ: if (out_free) begin
          if (pop_go) begin
            pop_cam_r <= {1'b0, nxt_cam};
          end else if (pop_active_r) begin
            // Slot fully emitted: remove it.
            mask_r[head_r] <= '0;
            head_r  <= head_inc;
            count_r <= count_r - NW'(1);
          end
        end
        S_POP_EMIT: if (out_free) begin
          o_kind_r   <= pop_deliver_r ? KIND_DELIVER : KIND_RELEASE;
          o_status_r <= pop_deliver_r ? ST_DELIVERED : ST_NEW;
          o_cam_r    <= 3'(pop_cam_r);
          o_hdl_r    <= hrd_q_r;
          o_size_r   <= srd_q_r;
          o_frame_r  <= pop_deliver_r ? st_frame_r : head_frame_r;
          o_last_r   <= 1'b0;
          pop_cam_r  <= pop_cam_r + (CW+1)'(1);
        end
        S_STATUS: if (out_free) begin
          if (pop_then_open_r) begin
            frame_mem[tail_slot] <= fr_r;
            mask_r[tail_slot]    <= CAMS'(1) << cam_r[CW-1:0];
            handle_mem[{tail_slot, cam_r[CW-1:0]}] <= hdl_r;
            size_mem[{tail_slot, cam_r[CW-1:0]}]   <= size_r;
            count_r  <= count_r + NW'(1);
          end
        end
        S_OUT_WAIT: if (out_free) begin
          o_kind_r   <= KIND_STATUS;
          o_status_r <= st_r;
          o_cam_r    <= '0;
          o_hdl_r    <= '0;
          o_size_r   <= '0;
          o_frame_r  <= st_frame_r;
          o_last_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Every state that loads the output register waits until it is free, so a late
  // part's release always leaves before its status.
  assign out_tvalid = out_v_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b0, dropped_r, delivered_r, opened_r, o_frame_r, o_size_r,
                       o_hdl_r, o_cam_r, o_status_r};

endmodule
